// ===== rtl/http2_data_frame_deframer_assert.svh =====
// Assertion macros for the HTTP/2 DATA frame deframer checker
`ifndef HTTP2_DATA_FRAME_DEFRAMER_ASSERT_SVH
`define HTTP2_DATA_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HDFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HDFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hdfd_pkg.sv =====
// Shared types and constants for the HTTP/2 DATA frame deframer
package hdfd_pkg;

  localparam logic [7:0] TypeData    = 8'h00;
  localparam logic [7:0] TypeHeaders = 8'h01;
  localparam int unsigned PaddedBit  = 3;     // PADDED flag is 0x08
  localparam int unsigned HeaderBytes = 9;

  typedef enum logic [2:0] {
    StOk           = 3'd0,
    StTooShort     = 3'd1,
    StPadExceeds   = 3'd2,
    StInsufficient = 3'd3,
    StHeaders      = 3'd4,
    StUnsupported  = 3'd5
  } hdfd_status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } hdfd_in_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_out;
    logic       frame_end;
    logic [2:0] frame_status;
  } hdfd_out_t;

endpackage

// ===== rtl/http2_data_frame_deframer.sv =====
// HTTP/2 DATA frame deframer: byte-wide parser feeding a result queue
//
// Input channel: one frame byte per transaction (push/full), frame_last set on
// the frame's final byte. The 9-byte header gives length, type and flags; the
// stream id is skipped. PADDED DATA frames lose their pad-length byte and
// trailing padding; bytes beyond the declared payload are dropped.
// Result channel (empty/pop): one transaction per DATA payload byte, plus one
// on the frame's last byte carrying frame_end and the status. The consumer
// must throw away a frame whose final status is not ok.
// Throughput: one byte per cycle while full is low. The parser is combinational
// (a 24-bit compare/subtract on the pad byte, a decrement otherwise).
// Results are written to the queue as their bytes are taken and show on out_o in order.
// The queue holds FifoDepth results; full rises only when it is full, so a
// stalled consumer back-pressures the byte stream after FifoDepth results.
// Bytes that give no result never occupy the queue.
// Reset (rst_ni low, asynchronous) empties the queue and clears all frame
// state, so the next byte taken is byte 0 of a new frame.
module http2_data_frame_deframer #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hdfd_pkg::hdfd_in_t  in_i,
  output logic               empty,
  input  logic               pop,
  output hdfd_pkg::hdfd_out_t out_o
);
  import hdfd_pkg::*;

  localparam int unsigned ResW = $bits(hdfd_out_t);

  logic      accept;
  logic      res_valid;
  hdfd_out_t res;
  logic      q_full;

  // a byte is taken whenever the queue has room, result or not
  assign accept = push && !q_full;
  assign full   = q_full;

  hdfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hdfd_fifo #(
    .Width (ResW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .full_o    (q_full),
    .rd_en_i   (pop),
    .rd_data_o (out_o),
    .empty_o   (empty)
  );

endmodule

// ===== rtl/hdfd_fifo.sv =====
// Register-based result queue between the parser and the output side
module hdfd_fifo #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/hdfd_front.sv =====
// Frame parser: tracks header fields and turns each byte into a result record
module hdfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hdfd_pkg::hdfd_in_t item_i,
  output logic              res_valid_o,
  output hdfd_pkg::hdfd_out_t res_o
);
  import hdfd_pkg::*;

  // Position saturates at PosSat: every position past the pad byte behaves alike
  localparam logic [3:0] PosSat = 4'(HeaderBytes + 1);
  localparam logic [3:0] PosPad = 4'(HeaderBytes);
  localparam logic [3:0] PosEnd = 4'(HeaderBytes - 1);

  logic [3:0]  pos_q, pos_d;
  logic [23:0] len_q, len_d;
  logic        data_q, data_d;
  logic        hdrs_q, hdrs_d;
  logic        padded_q, padded_d;
  logic [23:0] rem_q, rem_d;
  logic        bad_q, bad_d;

  logic [7:0]   b;
  logic [24:0]  need;
  logic         hb;
  hdfd_status_e status;

  assign b    = item_i.frame_byte;
  assign need = {17'd0, b} + 25'd1;

  always_comb begin
    len_d    = len_q;
    data_d   = data_q;
    hdrs_d   = hdrs_q;
    padded_d = padded_q;
    rem_d    = rem_q;
    bad_d    = bad_q;
    hb       = 1'b0;

    if (pos_q < 4'd3) begin
      len_d = {len_q[15:0], b};
    end else if (pos_q == 4'd3) begin
      data_d = (b == TypeData);
      hdrs_d = (b == TypeHeaders);
    end else if (pos_q == 4'd4) begin
      padded_d = b[PaddedBit];
      rem_d    = b[PaddedBit] ? '0 : len_q;
    end else if (pos_q >= PosPad && data_q) begin
      if (padded_q && pos_q == PosPad) begin
        if ({1'b0, len_q} < need) begin
          bad_d = 1'b1;
          rem_d = '0;
        end else begin
          rem_d = 24'({1'b0, len_q} - need);
        end
      end else if (rem_q != '0 && !bad_q) begin
        hb    = 1'b1;
        rem_d = rem_q - 24'd1;
      end
    end

    priority if (pos_q < PosEnd) begin
      status = StTooShort;
    end else if (hdrs_q) begin
      status = StHeaders;
    end else if (!data_q) begin
      status = StUnsupported;
    end else if (padded_q && pos_q == PosEnd) begin
      status = StInsufficient;
    end else if (bad_d) begin
      status = StPadExceeds;
    end else if (rem_d != '0) begin
      status = StInsufficient;
    end else begin
      status = StOk;
    end

    pos_d = (pos_q == PosSat) ? pos_q : pos_q + 4'd1;
  end

  assign res_valid_o        = accept_i && (hb || item_i.frame_last);
  assign res_o.has_byte     = hb;
  assign res_o.payload_out  = hb ? b : 8'd0;
  assign res_o.frame_end    = item_i.frame_last;
  assign res_o.frame_status = item_i.frame_last ? status : StOk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      data_q   <= 1'b1;   // cleared type byte reads as DATA
      hdrs_q   <= 1'b0;
      padded_q <= 1'b0;
      rem_q    <= '0;
      bad_q    <= 1'b0;
    end else if (accept_i) begin
      if (item_i.frame_last) begin
        pos_q    <= '0;
        len_q    <= '0;
        data_q   <= 1'b1;
        hdrs_q   <= 1'b0;
        padded_q <= 1'b0;
        rem_q    <= '0;
        bad_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        len_q    <= len_d;
        data_q   <= data_d;
        hdrs_q   <= hdrs_d;
        padded_q <= padded_d;
        rem_q    <= rem_d;
        bad_q    <= bad_d;
      end
    end
  end

endmodule

// ===== rtl/hdfd_checker.sv =====
// Port-level checker for the HTTP/2 DATA frame deframer, with its bind
`include "http2_data_frame_deframer_assert.svh"

module hdfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input hdfd_pkg::hdfd_out_t out_o
);
  import hdfd_pkg::*;

  logic idle_zero;

  // idle fields are zero: payload without a byte, status without a frame end
  assign idle_zero = (out_o.has_byte || out_o.payload_out == 8'd0) &&
                     (out_o.frame_end || out_o.frame_status == StOk);

  // no result transaction is ever blank
  `HDFD_ASSERT_NOW(a_not_blank, !empty, out_o.has_byte || out_o.frame_end, "blank result")

  `HDFD_ASSERT_NOW(a_idle_zero, !empty, idle_zero, "idle field not zero")

  // status codes stay within the defined set
  `HDFD_ASSERT_NOW(a_status_range, !empty && out_o.frame_end, out_o.frame_status <= StUnsupported, "undefined status")

  // a full queue always has a result waiting
  `HDFD_ASSERT_NOW(a_full_not_empty, full, !empty, "full with no result waiting")

  // a waiting result holds until popped
  `HDFD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_o), "result changed while stalled")

endmodule

bind http2_data_frame_deframer hdfd_checker u_hdfd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

// ===== dv/http2_data_frame_deframer_test.sv =====
// Self-checking testbench for the HTTP/2 DATA frame deframer
`timescale 1ns / 1ps

module http2_data_frame_deframer_test;
  import hdfd_pkg::*;

  // 8 ns clock. The slowest legal run is about 2.4k bytes. Each byte can see a
  // random gap at the sender and a random stall at the receiver, plus one long
  // hold-off. That is well within the limit below.
  localparam int unsigned ClkHalfNs  = 4;
  localparam int unsigned TimeoutNs  = 4_000_000;
  localparam int unsigned HoldCycles = 150;    // long receiver hold-off
  localparam int unsigned DrainCycles = 16;    // room for stray results after the drain
  localparam int unsigned RandomBytes = 1400;
  localparam int unsigned StreamBytes = 250;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  hdfd_in_t  in_i;
  logic      empty;
  logic      pop;
  hdfd_out_t out_o;

  http2_data_frame_deframer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  // Shadow copy of the parser's frame state. It is all zero after reset and
  // cleared again on every frame's last byte.
  logic [24:0] frame_idx   = '0;  // saturating byte index within the frame
  logic [23:0] len_field   = '0;
  logic [7:0]  type_byte   = '0;
  logic        pad_flag    = 1'b0;
  logic [7:0]  pad_len     = '0;
  logic [23:0] data_left   = '0;  // payload bytes still to pass out
  logic        pad_bad     = 1'b0;

  hdfd_out_t   expected_q[$];     // predicted results, oldest first
  int unsigned fault_cnt  = 0;
  int unsigned bytes_sent = 0;
  bit          idle_on    = 1'b1; // random gaps on both sides
  bit          hold_req   = 1'b0; // asks the receiver for one long hold-off

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalfNs) clk_i = ~clk_i;
  end

  // Hard limit on simulated time
  initial begin
    #(TimeoutNs);
    $display("http2_data_frame_deframer regression: fail");
    $finish;
  end

  // Works out what one accepted byte does to the frame state. It returns 1 when
  // the byte causes a result transaction, and hands that result back in res.
  function automatic bit deframe_byte(input hdfd_in_t item, output hdfd_out_t res);
    logic [7:0]   b;
    logic [24:0]  idx;
    logic [24:0]  pad_need;
    hdfd_status_e st;
    b   = item.frame_byte;
    idx = frame_idx;
    res = '0;
    st  = StOk;
    if (idx < 3) begin
      // big-endian 24-bit length
      len_field = {len_field[15:0], b};
    end else if (idx == 3) begin
      type_byte = b;
    end else if (idx == 4) begin
      pad_flag  = b[PaddedBit];
      data_left = pad_flag ? 24'd0 : len_field;  // padded: wait for the pad byte
    end else if (idx >= HeaderBytes && type_byte == TypeData) begin
      if (pad_flag && idx == HeaderBytes) begin
        // pad-length byte: the payload loses the padding and this byte
        pad_len  = b;
        pad_need = {17'd0, b} + 25'd1;
        if ({1'b0, len_field} < pad_need) begin
          pad_bad   = 1'b1;
          data_left = '0;
        end else begin
          data_left = len_field - pad_need[23:0];
        end
      end else if (data_left != 0 && !pad_bad) begin
        res.has_byte    = 1'b1;
        res.payload_out = b;
        data_left       = data_left - 24'd1;
      end
      // anything else is trailing padding or excess, dropped
    end

    if (item.frame_last) begin
      if (idx < HeaderBytes - 1)             st = StTooShort;
      else if (type_byte == TypeHeaders)     st = StHeaders;
      else if (type_byte != TypeData)        st = StUnsupported;
      else if (pad_flag && idx < HeaderBytes) st = StInsufficient;  // no pad byte
      else if (pad_bad)                      st = StPadExceeds;
      else if (data_left != 0)               st = StInsufficient;  // payload cut off
      res.frame_end    = 1'b1;
      res.frame_status = st;
      frame_idx  = '0;
      len_field  = '0;
      type_byte  = '0;
      pad_flag   = 1'b0;
      pad_len    = '0;
      data_left  = '0;
      pad_bad    = 1'b0;
    end else if (idx != '1) begin
      frame_idx = idx + 25'd1;
    end
    return res.has_byte || item.frame_last;
  endfunction

  task automatic note_fault(input string what, input hdfd_out_t want,
                            input hdfd_out_t got);
    if (fault_cnt < 10) begin
      $write("%0t ns: %s: expected has_byte=%0b payload=%02h end=%0b status=%0d, ",
             $time, what, want.has_byte, want.payload_out, want.frame_end,
             want.frame_status);
      $display("got has_byte=%0b payload=%02h end=%0b status=%0d",
               got.has_byte, got.payload_out, got.frame_end, got.frame_status);
    end
    fault_cnt++;
  endtask

  // Monitor: both handshakes are sampled at the rising edge. The DUT updates on
  // nonblocking assignments, so the values read here are the pre-edge ones.
  // A popped result is checked first, then an accepted byte is predicted.
  always @(posedge clk_i) begin : monitor
    hdfd_out_t want;
    hdfd_out_t res;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          note_fault("unexpected result", '0, out_o);
        end else begin
          want = expected_q.pop_front();
          if (out_o.has_byte !== want.has_byte || out_o.payload_out !== want.payload_out ||
              out_o.frame_end !== want.frame_end ||
              out_o.frame_status !== want.frame_status) begin
            note_fault("result mismatch", want, out_o);
          end
        end
      end
      if (push && !full) begin
        if (deframe_byte(in_i, res)) expected_q.push_back(res);
      end
    end
  end

  // Receiver. pop changes only at the falling edge, at most one assignment per edge.
  // It stalls in random bursts, or once for a long stretch when asked.
  initial begin : result_drain
    int stall;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 11);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offers one byte and returns once its transaction has been taken. The task
  // is entered just after a rising edge, so every falling edge it touches gets
  // exactly one assignment to push.
  task automatic push_byte(input logic [7:0] b, input logic last_flag);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push             <= 1'b1;
    in_i.frame_byte  <= b;
    in_i.frame_last  <= last_flag;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends n_bytes of a frame: the header from the arguments, a random stream id,
  // the pad byte at index 9 when the PADDED flag is set, random bytes after that.
  task automatic send_frame(input logic [23:0] len, input logic [7:0] ftype,
                            input logic [7:0] flags, input logic [7:0] pad,
                            input int n_bytes);
    logic [7:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      case (i)
        0: b = len[23:16];
        1: b = len[15:8];
        2: b = len[7:0];
        3: b = ftype;
        4: b = flags;
        9: b = flags[PaddedBit] ? pad : 8'($urandom_range(0, 255));
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b, i == n_bytes - 1);
    end
  endtask

  // Mostly well-formed frames with random content. A share of them are cut short,
  // carry excess bytes, stop inside the header, or claim a huge length.
  task automatic send_random_frame();
    logic [23:0] len;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [7:0]  pad;
    int          pick;
    int          body;
    int          n_bytes;
    pick = $urandom_range(0, 99);
    if (pick < 70)      ftype = TypeData;
    else if (pick < 82) ftype = TypeHeaders;
    else                ftype = 8'($urandom_range(0, 255));
    flags = 8'($urandom_range(0, 255));

    pick = $urandom_range(0, 19);
    if (pick == 0)     len = 24'($urandom_range(0, 24'hFFFFFF));
    else if (pick < 3) len = 24'($urandom_range(100, 300));
    else               len = 24'($urandom_range(0, 24));

    // usually a pad that fits, sometimes one that overruns the length
    if (len == 0 || $urandom_range(0, 4) == 0) pad = 8'($urandom_range(0, 255));
    else pad = 8'($urandom_range(0, (len > 256) ? 255 : len - 1));

    body = (len > 300) ? $urandom_range(0, 30) : int'(len);
    case ($urandom_range(0, 9))
      0:       n_bytes = $urandom_range(1, HeaderBytes);
      1:       n_bytes = HeaderBytes + $urandom_range(0, body);
      2:       n_bytes = HeaderBytes + body + $urandom_range(1, 6);
      default: n_bytes = HeaderBytes + body;
    endcase
    send_frame(len, ftype, flags, pad, n_bytes);
  endtask

  // --- directed tests ---

  // A lone 0xFF byte marked last: too short.
  task automatic test_short_frame();
    send_frame(24'hFFFFFF, 8'hFF, 8'hFF, 8'h00, 1);
  endtask

  // HEADERS ends right at its header. The unsupported type carries one byte that
  // must not pass.
  task automatic test_non_data_types();
    send_frame(24'd4, TypeHeaders, 8'h08, 8'h00, HeaderBytes);
    send_frame(24'd1, 8'hFF, 8'h00, 8'h00, HeaderBytes + 1);
  endtask

  // PADDED cases: no pad byte, a pad larger than the length, and a good frame
  // with one payload byte, one pad byte and one excess byte.
  task automatic test_padding();
    send_frame(24'd5, TypeData, 8'h08, 8'h00, HeaderBytes);
    send_frame(24'd0, TypeData, 8'hFF, 8'h00, HeaderBytes + 1);
    send_frame(24'd3, TypeData, 8'h08, 8'h01, HeaderBytes + 4);
  endtask

  // An empty DATA frame is fine; a full-scale length with one byte is cut off.
  task automatic test_payload_length();
    send_frame(24'd0, TypeData, 8'h00, 8'h00, HeaderBytes);
    send_frame(24'hFFFFFF, TypeData, 8'h00, 8'h00, HeaderBytes + 1);
  endtask

  // The receiver stops for a long stretch during a long payload. The result queue
  // fills, full rises and the sender has to wait.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_frame(24'd60, TypeData, 8'h00, 8'h00, HeaderBytes + 60);
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // Final stretch at full rate: no gaps at either side.
  task automatic test_streaming();
    int unsigned stop_at;
    idle_on = 1'b0;
    stop_at = bytes_sent + StreamBytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // Main sequence
  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    push   = 1'b0;
    in_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_frame();
    test_non_data_types();
    test_padding();
    test_payload_length();
    test_backpressure();
    test_random_frames();
    test_streaming();

    @(negedge clk_i);
    push <= 1'b0;

    // let outstanding transactions drain, then leave room for strays
    while (expected_q.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end

    if (fault_cnt == 0 && expected_q.size() == 0) begin
      $display("http2_data_frame_deframer regression: pass");
    end else begin
      $display("http2_data_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule

// ===== http2_data_frame_deframer.f =====
+incdir+rtl
rtl/hdfd_pkg.sv
rtl/hdfd_fifo.sv
rtl/hdfd_front.sv
rtl/http2_data_frame_deframer.sv
rtl/hdfd_checker.sv
dv/http2_data_frame_deframer_test.sv
